@@ rtl/core/sequential_list_engine_core_defines.svh @@
// Assertion macros used by the list engine core.
`ifndef SEQUENTIAL_LIST_ENGINE_CORE_DEFINES_SVH
`define SEQUENTIAL_LIST_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SLE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define SLE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/sle_pkg.sv @@
// Shared constants, codes and types of the list engine.
package sle_pkg;

	localparam int CAPACITY = 32;
	localparam int ELEM_W   = 32;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int POS_W    = 6;

	// Request operation codes.
	typedef enum logic [1:0] {
		FUNC_GET    = 2'd0,
		FUNC_INSERT = 2'd1,
		FUNC_DELETE = 2'd2,
		FUNC_FIND   = 2'd3
	} func_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		S_IDLE    = 2'd0,
		S_EXEC    = 2'd1,
		S_RESOLVE = 2'd2
	} state_t;

	// Operation broadcast to every cell.
	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_INSERT = 2'd1,
		CELL_DELETE = 2'd2,
		CELL_FIND   = 2'd3
	} cell_op_t;

	typedef struct packed {
		cell_op_t          op;
		logic [IDX_W-1:0]  pos_idx;
		logic [ELEM_W-1:0] key;
		logic [CNT_W-1:0]  count;
	} cell_ctrl_t;

endpackage

@@ rtl/core/sequential_list_engine_core.sv @@
// Flow: the sequencer takes an item in idle, executes it, then resolves the
// cell match flags into the m_ side output register; a waiting result holds resolve.
// A new item is taken only in idle, after the last one has been resolved;
// it can be taken while that result still waits on the m_ side.
// Reset clears the element count, the sequencer and the output valid flag;
// the element cells are not cleared and need no clearing pass.
`include "sequential_list_engine_core_defines.svh"

module sequential_list_engine_core
	import sle_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // position[5:0], element_value[37:6], zero[39:38]
	input  logic [1:0]  s_tuser,  // func[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	// status[1:0], read_value[33:2], found[34], found_index[39:35],
	// list_length[45:40], zero[47:46]
	output logic [47:0] m_tdata
);

	state_t            state_q;
	state_t            state_n;
	func_t             func_s1;
	logic [POS_W-1:0]  pos_s1;
	logic [ELEM_W-1:0] key_s1;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_n;
	status_t           st_q;
	status_t           st_n;
	logic [ELEM_W-1:0] rd_q;
	logic [ELEM_W-1:0] rd_n;
	logic              is_find_q;
	logic              pos_lo_ok;
	logic              pos_hi_ok;
	logic              pos_ins_ok;
	logic [IDX_W-1:0]  pos_idx;
	cell_ctrl_t        ctrl;
	logic              s_accept;
	logic              out_load;
	logic              any_match;
	logic [IDX_W-1:0]  match_idx;

	logic [ELEM_W-1:0] cell_val   [CAPACITY];
	logic [CAPACITY-1:0] cell_match;

	status_t           out_status_q;
	logic [ELEM_W-1:0] out_read_q;
	logic              out_found_q;
	logic [IDX_W-1:0]  out_fidx_q;
	logic [CNT_W-1:0]  out_len_q;
	logic              m_tvalid_q;

	assign s_tready = (state_q == S_IDLE);
	assign s_accept = s_tvalid && s_tready;
	assign out_load = (state_q == S_RESOLVE) && (!m_tvalid_q || m_tready);

	// Captured request.
	always_ff @(posedge clk) begin
		if (s_accept) begin
			func_s1 <= func_t'(s_tuser);
			pos_s1  <= s_tdata[POS_W-1:0];
			key_s1  <= s_tdata[POS_W +: ELEM_W];
		end
	end

	// Position checks against the current element count.
	always_comb begin
		pos_lo_ok  = (pos_s1 != '0);
		pos_hi_ok  = ({1'b0, pos_s1} <= (CNT_W + 1)'(count_q));
		pos_ins_ok = ({1'b0, pos_s1} <= ((CNT_W + 1)'(count_q) + (CNT_W + 1)'(1)));
		pos_idx    = IDX_W'(pos_s1 - POS_W'(1));
	end

	// Execute decision: status, cell operation, read data and new count.
	always_comb begin
		st_n       = ST_OK;
		rd_n       = '0;
		count_n    = count_q;
		ctrl.op    = CELL_HOLD;
		ctrl.pos_idx = pos_idx;
		ctrl.key   = key_s1;
		ctrl.count = count_q;
		if (state_q == S_EXEC) begin
			case (func_s1)
				FUNC_GET: begin
					if (pos_lo_ok && pos_hi_ok) begin
						rd_n = cell_val[pos_idx];
					end else begin
						st_n = ST_RANGE;
					end
				end
				FUNC_INSERT: begin
					if (!(pos_lo_ok && pos_ins_ok)) begin
						st_n = ST_RANGE;
					end else if (count_q == CNT_W'(CAPACITY)) begin
						st_n = ST_FULL;
					end else begin
						ctrl.op = CELL_INSERT;
						count_n = count_q + CNT_W'(1);
					end
				end
				FUNC_DELETE: begin
					if (pos_lo_ok && pos_hi_ok) begin
						rd_n    = cell_val[pos_idx];
						ctrl.op = CELL_DELETE;
						count_n = count_q - CNT_W'(1);
					end else begin
						st_n = ST_RANGE;
					end
				end
				FUNC_FIND: begin
					ctrl.op = CELL_FIND;
				end
				default: begin
					ctrl.op = CELL_HOLD;
				end
			endcase
		end
	end

	// Chain of element cells, each fed by its neighbors.
	for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
		logic [ELEM_W-1:0] prev_v;
		logic [ELEM_W-1:0] next_v;
		if (k == 0) begin : g_first
			assign prev_v = key_s1;
		end else begin : g_mid_lo
			assign prev_v = cell_val[k-1];
		end
		if (k == CAPACITY - 1) begin : g_last
			assign next_v = cell_val[k];
		end else begin : g_mid_hi
			assign next_v = cell_val[k+1];
		end
		sle_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.idx        (IDX_W'(k)),
			.prev_value (prev_v),
			.next_value (next_v),
			.value      (cell_val[k]),
			.match      (cell_match[k])
		);
	end

	// Lowest matching cell wins.
	always_comb begin
		match_idx = '0;
		for (int k = CAPACITY - 1; k >= 0; k--) begin
			if (cell_match[k]) begin
				match_idx = IDX_W'(k);
			end
		end
		any_match = |cell_match;
	end

	// Sequencer next state.
	always_comb begin
		state_n = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_accept) begin
					state_n = S_EXEC;
				end
			end
			S_EXEC: begin
				state_n = S_RESOLVE;
			end
			S_RESOLVE: begin
				if (out_load) begin
					state_n = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	// Sequencer state and element count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_n;
			count_q <= count_n;
		end
	end

	// Execute results held for the resolve cycle.
	always_ff @(posedge clk) begin
		if (state_q == S_EXEC) begin
			st_q      <= st_n;
			rd_q      <= rd_n;
			is_find_q <= (func_s1 == FUNC_FIND);
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= st_q;
			out_read_q   <= rd_q;
			out_found_q  <= is_find_q && any_match;
			out_fidx_q   <= (is_find_q && any_match) ? match_idx : '0;
			out_len_q    <= count_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, out_len_q, out_fidx_q, out_found_q, out_read_q, out_status_q};

	`SLE_ASSERT_IMP(a_count_range, 1'b1, count_q <= CNT_W'(CAPACITY),
		"element count above capacity")
	`SLE_ASSERT_NXT(a_count_stable, state_q != S_EXEC, $stable(count_q),
		"element count changed outside execute")
	`SLE_ASSERT_IMP(a_full_len, m_tvalid_q && (out_status_q == ST_FULL),
		out_len_q == CNT_W'(CAPACITY), "full status with list not full")
	`SLE_ASSERT_IMP(a_found_idx, m_tvalid_q && !out_found_q, out_fidx_q == '0,
		"nonzero index without a match")

endmodule

@@ rtl/core/sle_cell.sv @@
// One storage cell of the list chain: holds an element, shifts and compares.
module sle_cell
	import sle_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cell_ctrl_t        ctrl,
	input  logic [IDX_W-1:0]  idx,
	input  logic [ELEM_W-1:0] prev_value,
	input  logic [ELEM_W-1:0] next_value,
	output logic [ELEM_W-1:0] value,
	output logic              match
);

	logic [ELEM_W-1:0] value_q;
	logic [ELEM_W-1:0] value_n;
	logic              match_q;
	logic              match_n;

	// Next element: take the key, the lower neighbor or the upper neighbor.
	always_comb begin
		value_n = value_q;
		case (ctrl.op)
			CELL_INSERT: begin
				if (idx == ctrl.pos_idx) begin
					value_n = ctrl.key;
				end else if (idx > ctrl.pos_idx) begin
					value_n = prev_value;
				end
			end
			CELL_DELETE: begin
				if (idx >= ctrl.pos_idx) begin
					value_n = next_value;
				end
			end
			default: begin
				value_n = value_q;
			end
		endcase
	end

	// Match only counts for occupied cells.
	always_comb begin
		match_n = (value_q == ctrl.key) && ({1'b0, idx} < ctrl.count);
	end

	// Element storage.
	always_ff @(posedge clk) begin
		value_q <= value_n;
	end

	// Match flag is captured on a find and held until the next one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctrl.op == CELL_FIND) begin
			match_q <= match_n;
		end
	end

	assign value = value_q;
	assign match = match_q;

endmodule

@@ dv/tb_sequential_list_engine_core.sv @@
// Self-checking testbench for the sequential list engine core.
module tb_sequential_list_engine_core;
	import sle_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS   = 550;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 12;
	localparam int REPORT_LIMIT   = 10;

	// Values that get picked often, so that find hits and the extremes recur.
	localparam logic [ELEM_W-1:0] VALUE_POOL [8] = '{
		32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF,
		32'h8000_0000, 32'd20, 32'h5555_5555, 32'hAAAA_AAAA
	};

	// One result of the list, one field per member.
	typedef struct packed {
		status_t           status;
		logic [ELEM_W-1:0] read_value;
		logic              found;
		logic [4:0]        found_index;
		logic [5:0]        list_length;
	} list_result_t;

	// One row of the directed table; want is used only when typed is set.
	typedef struct packed {
		func_t             func;
		logic [POS_W-1:0]  pos;
		logic [ELEM_W-1:0] val;
		logic              typed;
		list_result_t      want;
	} request_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;

	// Our own copy of the list contents and length.
	logic [ELEM_W-1:0] held_words [CAPACITY];
	int                held_count;

	list_result_t expected_results [$];
	int           mismatch_count;
	int           idle_cycles;
	bit           tx_idle;
	bit           rx_idle;

	sequential_list_engine_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #4 clk = ~clk;

	// Apply one request to the list copy and return the result it gives.
	function automatic list_result_t run_list_request(input func_t f,
			input logic [POS_W-1:0] pos, input logic [ELEM_W-1:0] val);
		list_result_t r;
		int p;
		int n;
		int k;
		r = '0;
		p = pos;
		n = held_count;
		case (f)
			FUNC_GET: begin
				if (p < 1 || p > n) r.status = ST_RANGE;
				else r.read_value = held_words[p-1];
			end
			FUNC_INSERT: begin
				// The range check wins over the full check.
				if (p < 1 || p > n + 1) begin
					r.status = ST_RANGE;
				end else if (n >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					for (k = n; k >= p; k--) held_words[k] = held_words[k-1];
					held_words[p-1] = val;
					held_count++;
				end
			end
			FUNC_DELETE: begin
				if (p < 1 || p > n) begin
					r.status = ST_RANGE;
				end else begin
					r.read_value = held_words[p-1];
					for (k = p; k < n; k++) held_words[k-1] = held_words[k];
					held_count--;
				end
			end
			default: begin
				// Only held entries take part in the search.
				for (k = 0; k < n; k++) begin
					if (!r.found && held_words[k] == val) begin
						r.found       = 1'b1;
						r.found_index = k[4:0];
					end
				end
			end
		endcase
		r.list_length = held_count[5:0];
		return r;
	endfunction

	// Offer one item after a random gap, then log what it should produce.
	task automatic send_request(input func_t f, input logic [POS_W-1:0] pos,
			input logic [ELEM_W-1:0] val, input logic typed, input list_result_t want);
		int gap;
		list_result_t predicted;
		gap = tx_idle ? $urandom_range(0, 10) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tuser  <= f;
		s_tdata  <= {2'b00, val, pos};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		predicted = run_list_request(f, pos, val);
		expected_results.push_back(typed ? want : predicted);
	endtask

	// Stimulus: reset, the directed table, then random traffic.
	initial begin
		request_row_t directed_rows [25];
		func_t f;
		logic [POS_W-1:0] pos;
		logic [ELEM_W-1:0] val;
		int i;
		int n;
		int roll;
		int mode;
		int sel;

		held_count     = 0;
		mismatch_count = 0;
		tx_idle        = 1'b1;
		for (i = 0; i < CAPACITY; i++) held_words[i] = '0;

		directed_rows = '{
			// Empty list: get, delete and inserts off position 1 are out of range.
			'{FUNC_GET,    6'd1,  32'd0, 1'b1, '{ST_RANGE, 32'd0, 1'b0, 5'd0, 6'd0}},
			'{FUNC_DELETE, 6'd1,  32'd0, 1'b1, '{ST_RANGE, 32'd0, 1'b0, 5'd0, 6'd0}},
			'{FUNC_FIND,   6'd0,  32'd0, 1'b1, '{ST_OK,    32'd0, 1'b0, 5'd0, 6'd0}},
			'{FUNC_INSERT, 6'd0,  32'd5, 1'b1, '{ST_RANGE, 32'd0, 1'b0, 5'd0, 6'd0}},
			'{FUNC_INSERT, 6'd2,  32'd5, 1'b1, '{ST_RANGE, 32'd0, 1'b0, 5'd0, 6'd0}},
			'{FUNC_INSERT, 6'd1,  32'h7FFF_FFFF, 1'b1,
				'{ST_OK, 32'd0, 1'b0, 5'd0, 6'd1}},
			'{FUNC_INSERT, 6'd1,  32'h8000_0000, 1'b1,
				'{ST_OK, 32'd0, 1'b0, 5'd0, 6'd2}},
			// Insert at the last occupied position must shift it, not overwrite.
			'{FUNC_INSERT, 6'd2,  32'hFFFF_FFFF, 1'b0, '0},
			'{FUNC_GET,    6'd3,  32'd0, 1'b1, '{ST_OK, 32'h7FFF_FFFF, 1'b0, 5'd0, 6'd3}},
			'{FUNC_GET,    6'd2,  32'd0, 1'b0, '0},
			'{FUNC_GET,    6'd4,  32'd0, 1'b1, '{ST_RANGE, 32'd0, 1'b0, 5'd0, 6'd3}},
			'{FUNC_GET,    6'd63, 32'd0, 1'b1, '{ST_RANGE, 32'd0, 1'b0, 5'd0, 6'd3}},
			'{FUNC_FIND,   6'd63, 32'hFFFF_FFFF, 1'b0, '0},
			'{FUNC_FIND,   6'd1,  32'd0, 1'b0, '0},
			'{FUNC_INSERT, 6'd4,  32'd0, 1'b0, '0},
			'{FUNC_INSERT, 6'd63, 32'd1, 1'b1, '{ST_RANGE, 32'd0, 1'b0, 5'd0, 6'd4}},
			'{FUNC_INSERT, 6'd6,  32'd1, 1'b1, '{ST_RANGE, 32'd0, 1'b0, 5'd0, 6'd4}},
			'{FUNC_INSERT, 6'd1,  32'hFFFF_FFFF, 1'b0, '0},
			// Duplicate values: the lowest index is reported.
			'{FUNC_FIND,   6'd0,  32'hFFFF_FFFF, 1'b0, '0},
			'{FUNC_DELETE, 6'd1,  32'd0, 1'b1, '{ST_OK, 32'hFFFF_FFFF, 1'b0, 5'd0, 6'd4}},
			'{FUNC_DELETE, 6'd0,  32'd0, 1'b1, '{ST_RANGE, 32'd0, 1'b0, 5'd0, 6'd4}},
			'{FUNC_DELETE, 6'd5,  32'd0, 1'b1, '{ST_RANGE, 32'd0, 1'b0, 5'd0, 6'd4}},
			'{FUNC_DELETE, 6'd4,  32'd0, 1'b0, '0},
			// A stale word beyond the length must not match.
			'{FUNC_FIND,   6'd0,  32'd0, 1'b0, '0},
			'{FUNC_GET,    6'd0,  32'd0, 1'b1, '{ST_RANGE, 32'd0, 1'b0, 5'd0, 6'd3}}
		};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < 25; i++) begin
			send_request(directed_rows[i].func, directed_rows[i].pos, directed_rows[i].val,
				directed_rows[i].typed, directed_rows[i].want);
		end

		// Random traffic in phases that fill, drain or mix, so the list
		// regularly reaches both empty and full.
		mode = 0;
		for (i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 50 == 0) begin
				tx_idle = ($urandom_range(0, 3) != 0);
				mode    = $urandom_range(0, 2);
			end
			n    = held_count;
			roll = $urandom_range(0, 99);
			case (mode)
				0: f = roll < 65 ? FUNC_INSERT : roll < 75 ? FUNC_GET :
					roll < 85 ? FUNC_FIND : FUNC_DELETE;
				1: f = roll < 55 ? FUNC_DELETE : roll < 70 ? FUNC_GET :
					roll < 85 ? FUNC_FIND : FUNC_INSERT;
				default: f = func_t'($urandom_range(0, 3));
			endcase

			if ($urandom_range(0, 9) < 4) val = VALUE_POOL[$urandom_range(0, 7)];
			else val = $urandom;
			if (f == FUNC_FIND && n > 0 && $urandom_range(0, 9) < 6)
				val = held_words[$urandom_range(0, n - 1)];

			// Mostly legal positions, with the boundaries favored.
			if (f == FUNC_FIND) begin
				pos = $urandom_range(0, 63);
			end else if (f == FUNC_INSERT) begin
				if ($urandom_range(0, 9) == 0) begin
					pos = $urandom_range(0, 1) ? '0 : POS_W'($urandom_range(n + 2, 63));
				end else begin
					sel = $urandom_range(0, 3);
					pos = sel == 0 ? POS_W'(n) : sel == 1 ? POS_W'(n + 1) :
						POS_W'($urandom_range(1, n + 1));
					if (pos == 0) pos = 1;
				end
			end else begin
				if (n == 0 || $urandom_range(0, 9) == 0)
					pos = $urandom_range(0, 1) ? '0 : POS_W'($urandom_range(n + 1, 63));
				else
					pos = $urandom_range(1, n);
			end

			send_request(f, pos, val, 1'b0, '0);
		end
		s_tvalid <= 1'b0;

		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("sequential_list_engine_core: match");
		else
			$display("sequential_list_engine_core: mismatch");
		$finish;
	end

	// Result side: random back-pressure, then compare against the oldest expectation.
	initial begin
		int stall;
		int taken;
		list_result_t got;
		list_result_t want;

		taken   = 0;
		rx_idle = 1'b1;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (taken % 40 == 0) rx_idle = ($urandom_range(0, 3) != 0);
			stall = rx_idle ? $urandom_range(0, 10) : 0;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			taken++;

			got.status      = status_t'(m_tdata[1:0]);
			got.read_value  = m_tdata[33:2];
			got.found       = m_tdata[34];
			got.found_index = m_tdata[39:35];
			got.list_length = m_tdata[45:40];

			if (expected_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("%0t: result with nothing pending: %p", $realtime, got);
			end else begin
				want = expected_results.pop_front();
				if (got.status !== want.status || got.read_value !== want.read_value ||
						got.found !== want.found || got.found_index !== want.found_index ||
						got.list_length !== want.list_length) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("%0t: result %0d wrong: expected %p, got %p",
							$realtime, taken, want, got);
				end
			end
		end
	end

	// Watchdog: too long without any item moving on either side ends the run.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("sequential_list_engine_core: mismatch");
			$finish;
		end
	end

endmodule
